@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/b64lw_pkg.sv @@
`default_nettype none

package b64lw_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0]  REG_WRAP_GROUPS = 1'b0;
  localparam logic [5:0]  WRAP_GROUPS_RESET = 6'd19;

  localparam logic [7:0] CH_PAD = 8'h3D;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Index of the final character in a command: a group with or without CR LF.
  localparam logic [2:0] LAST_IDX_GROUP = 3'd3;
  localparam logic [2:0] LAST_IDX_WRAP  = 3'd5;

  typedef enum logic [1:0] {
    POS_EMPTY = 2'd0,
    POS_ONE   = 2'd1,
    POS_TWO   = 2'd2
  } pos_t;

  // One burst of up to six output characters, emitted in order chars[0..last_idx].
  typedef struct packed {
    logic [5:0][7:0] chars;
    logic [2:0]      last_idx;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/b64lw_front.sv @@
`default_nettype none
`include "assert_macros.svh"

module b64lw_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  input  wire logic [5:0]      wrap_groups,
  input  wire logic            q_full,
  output logic                 q_push,
  output b64lw_pkg::cmd_t      q_cmd
);
  import b64lw_pkg::*;

  pos_t       pos, pos_next;
  logic [7:0] held_a, held_a_next;
  logic [7:0] held_c, held_c_next;
  logic [5:0] line_cnt, line_cnt_next;
  logic       accept;
  logic [5:0] cnt_inc;
  logic       wrap;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = line_cnt + 6'd1;
  assign wrap     = (wrap_groups != 6'd0) && (cnt_inc >= wrap_groups);

  always_comb begin
    pos_next      = pos;
    held_a_next   = held_a;
    held_c_next   = held_c;
    line_cnt_next = line_cnt;
    q_push        = 1'b0;
    q_cmd         = '0;
    q_cmd.last    = last_byte;
    if (accept) begin
      case (pos)
        POS_TWO: begin
          q_push         = 1'b1;
          q_cmd.chars[0] = sym(held_a[7:2]);
          q_cmd.chars[1] = sym({held_a[1:0], held_c[7:4]});
          q_cmd.chars[2] = sym({held_c[3:0], data_byte[7:6]});
          q_cmd.chars[3] = sym(data_byte[5:0]);
          q_cmd.chars[4] = CH_CR;
          q_cmd.chars[5] = CH_LF;
          q_cmd.last_idx = wrap ? LAST_IDX_WRAP : LAST_IDX_GROUP;
          line_cnt_next  = wrap ? 6'd0 : cnt_inc;
          pos_next       = POS_EMPTY;
        end
        POS_ONE: begin
          held_c_next = data_byte;
          if (last_byte) begin
            q_push         = 1'b1;
            q_cmd.chars[0] = sym(held_a[7:2]);
            q_cmd.chars[1] = sym({held_a[1:0], data_byte[7:4]});
            q_cmd.chars[2] = sym({data_byte[3:0], 2'b00});
            q_cmd.chars[3] = CH_PAD;
            q_cmd.last_idx = LAST_IDX_GROUP;
          end else begin
            pos_next = POS_TWO;
          end
        end
        default: begin
          held_a_next = data_byte;
          if (last_byte) begin
            q_push         = 1'b1;
            q_cmd.chars[0] = sym(data_byte[7:2]);
            q_cmd.chars[1] = sym({data_byte[1:0], 4'b0000});
            q_cmd.chars[2] = CH_PAD;
            q_cmd.chars[3] = CH_PAD;
            q_cmd.last_idx = LAST_IDX_GROUP;
          end else begin
            pos_next = POS_ONE;
          end
        end
      endcase
      if (last_byte) begin
        pos_next      = POS_EMPTY;
        line_cnt_next = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_EMPTY;
      line_cnt <= 6'd0;
    end else begin
      pos      <= pos_next;
      line_cnt <= line_cnt_next;
    end
    held_a <= held_a_next;
    held_c <= held_c_next;
  end

  `ASSERT_NEXT(a_last_clears, clk, rst, accept && last_byte, (pos == POS_EMPTY) && (line_cnt == 6'd0), "line state not cleared after final byte")
  `ASSERT_IMPLY(a_push_on_group, clk, rst, q_push, (pos == POS_TWO) || last_byte, "burst pushed without a complete or final group")

endmodule

`default_nettype wire

@@ rtl/b64lw_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"

module b64lw_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64lw_pkg::cmd_t push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output b64lw_pkg::cmd_t      head
);
  import b64lw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CntW'(Depth), "queue count above depth")
  `ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

@@ rtl/b64lw_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module b64lw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire b64lw_pkg::cmd_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char,
  output logic                 last_char
);
  import b64lw_pkg::*;

  logic [2:0] idx, idx_next;
  logic       at_end;

  assign out_valid = !q_empty;
  assign at_end    = (idx == q_head.last_idx);
  assign out_char  = q_head.chars[idx];
  assign last_char = q_head.last && at_end;
  assign q_pop     = out_valid && out_ready && at_end;

  always_comb begin
    idx_next = idx;
    if (out_valid && out_ready) idx_next = at_end ? 3'd0 : idx + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= 3'd0;
    else     idx <= idx_next;
  end

  `ASSERT_IMPLY(a_idx_in_burst, clk, rst, out_valid, idx <= q_head.last_idx, "character index past end of burst")
  `ASSERT_NEXT(a_idx_restart, clk, rst, q_pop, idx == 3'd0, "index not rewound after burst")

endmodule

`default_nettype wire

@@ rtl/base64_encoder_line_wrap.sv @@
// Streaming base64 encoder with CR LF line wrap.
// Input channel (in_valid/in_ready): one raw byte per beat in data_byte, with
// last_byte set on the final byte of a message. Output channel
// (out_valid/out_ready): one ASCII character per beat in out_char, with
// last_char on the final character of the encoded message.
// Every third byte, and every final byte, produces a burst of 4 characters
// (6 when CR LF closes the line); other bytes produce nothing. Each burst
// is registered into the queue; its characters go out from the queue head.
// The output emits one character per cycle while out_ready is high and the
// queue holds a burst, so sustained intake is set by the output port. A
// FifoDepth-deep burst queue sits between the byte front end and the
// character serializer; bytes are taken at one per cycle while the queue
// has room, and in_ready drops only when it is full.
// wrap_groups (APB, address 0, reset 19) sets groups per line; 0 turns wrap
// off. Write it only while idle.
// Reset clears the byte position, the line count and the queue; when the
// receiver stalls the current character holds and the queue fills.
`default_nettype none

module base64_encoder_line_wrap #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [b64lw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         last_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_char,
  output logic                              last_char
);
  import b64lw_pkg::*;

  logic [5:0] wrap_groups;
  logic       reg_hit;
  cmd_t       push_cmd, head;
  logic       push, full, pop, empty;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_WRAP_GROUPS);
  assign prdata  = reg_hit ? {26'd0, wrap_groups} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_groups <= WRAP_GROUPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      wrap_groups <= pwdata[5:0];
    end
  end

  b64lw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .wrap_groups(wrap_groups),
    .q_full     (full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  b64lw_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  b64lw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .last_char(last_char)
  );

endmodule

`default_nettype wire

@@ tb/sv/base64_char_checker.sv @@
`timescale 1ns / 1ps

module base64_char_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [b64lw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [7:0]                   out_char,
  input  logic                         last_char,
  output int unsigned                  chars_outstanding,
  output int unsigned                  fail_count
);
  import b64lw_pkg::*;

  localparam logic [ADDR_W-1:0] WRAP_ADDR = ADDR_W'(4 * REG_WRAP_GROUPS);
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  enc_char_t   expected_chars[$];
  logic [5:0]  line_limit;
  logic [15:0] pending_bytes;
  pos_t        pending_count;
  logic [5:0]  groups_on_line;
  int unsigned mismatches = 0;

  // first character of the literal sits in the top byte
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  function automatic void queue_char(input logic [7:0] c);
    enc_char_t item;
    item.ch  = c;
    item.fin = 1'b0;
    expected_chars.insert(expected_chars.size(), item);
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] a;
    logic [7:0] c;
    enc_char_t  tail;
    int         first;
    first = expected_chars.size();
    case (pending_count)
      POS_EMPTY: begin
        pending_bytes = {b, 8'h00};
        if (fin) begin
          queue_char(b64_char(b[7:2]));
          queue_char(b64_char({b[1:0], 4'h0}));
          queue_char(CH_PAD);
          queue_char(CH_PAD);
        end else begin
          pending_count = POS_ONE;
        end
      end
      POS_ONE: begin
        a = pending_bytes[15:8];
        pending_bytes = {a, b};
        if (fin) begin
          queue_char(b64_char(a[7:2]));
          queue_char(b64_char({a[1:0], b[7:4]}));
          queue_char(b64_char({b[3:0], 2'b00}));
          queue_char(CH_PAD);
        end else begin
          pending_count = POS_TWO;
        end
      end
      default: begin
        a = pending_bytes[15:8];
        c = pending_bytes[7:0];
        queue_char(b64_char(a[7:2]));
        queue_char(b64_char({a[1:0], c[7:4]}));
        queue_char(b64_char({c[3:0], b[7:6]}));
        queue_char(b64_char(b[5:0]));
        groups_on_line = groups_on_line + 6'd1;
        // CR LF goes out even when this group closes the message
        if (line_limit != 6'd0 && groups_on_line >= line_limit) begin
          queue_char(CH_CR);
          queue_char(CH_LF);
          groups_on_line = 6'd0;
        end
        pending_bytes = 16'h0000;
        pending_count = POS_EMPTY;
      end
    endcase
    if (fin) begin
      if (expected_chars.size() > first) begin
        tail = expected_chars.pop_back();
        tail.fin = 1'b1;
        expected_chars.insert(expected_chars.size(), tail);
      end
      pending_bytes  = 16'h0000;
      pending_count  = POS_EMPTY;
      groups_on_line = 6'd0;
    end
  endtask

  always @(posedge clk) begin
    enc_char_t want;
    if (rst) begin
      line_limit     = WRAP_GROUPS_RESET;
      pending_bytes  = 16'h0000;
      pending_count  = POS_EMPTY;
      groups_on_line = 6'd0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: char beat with nothing expected: expected none, actual %h last %b",
                   $time, out_char, last_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h, actual %h", $time, want.ch, out_char);
            mismatches++;
          end
          if (last_char !== want.fin) begin
            $display("%0t: last_char expected %b, actual %b", $time, want.fin, last_char);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) encode_byte(data_byte, last_byte);
      if (psel && penable && pwrite && pready && paddr == WRAP_ADDR) begin
        line_limit = pwdata[5:0];
      end
    end
    chars_outstanding <= expected_chars.size();
    fail_count        <= mismatches;
  end

endmodule

@@ tb/sv/tb_base64_encoder_line_wrap.sv @@
`timescale 1ns / 1ps

module tb_base64_encoder_line_wrap;
  import b64lw_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [ADDR_W-1:0] WRAP_ADDR = ADDR_W'(4 * REG_WRAP_GROUPS);

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = 8'h00;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_char;
  logic              last_char;

  int unsigned chars_outstanding;
  int unsigned fail_count;
  int unsigned sender_idle_pct   = 29;
  int unsigned receiver_idle_pct = 62;
  int unsigned quiet_cycles      = 0;

  base64_encoder_line_wrap u_dut (.*);

  base64_char_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_byte(input logic [7:0] value, input logic fin);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_bytes(input int unsigned count, input logic fin);
    for (int unsigned i = 0; i < count; i++) begin
      send_byte(8'($urandom()), fin && (i == count - 1));
    end
  endtask

  // whole messages of random length; a few long ones to cross the line limit
  task automatic send_messages(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(4, 0) == 0) len = $urandom_range(70, 20);
      else len = $urandom_range(12, 1);
      send_random_bytes(len, 1'b1);
      sent += len;
    end
  endtask

  // drop valid, wait for every expected char, then let the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [5:0] groups);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WRAP_ADDR;
    pwdata  <= 32'(groups);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset line limit
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    // three groups on the line, then the limit drops below the count
    send_random_bytes(9, 1'b0);
    settle();
    set_line_limit(6'd2);
    send_random_bytes(3, 1'b0);
    send_random_bytes(1, 1'b1);
    settle();

    set_line_limit(6'd1);
    send_messages(20);
    settle();
    set_line_limit(6'd63);
    send_messages(20);
    settle();

    sender_idle_pct   = 62;
    receiver_idle_pct = 29;
    set_line_limit(6'd2);
    send_messages(20);
    settle();
    set_line_limit(6'($urandom_range(8, 3)));
    send_messages(20);
    settle();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    // wrap off: 20 groups pile up on the line, so the next limit is already passed
    set_line_limit(6'd0);
    send_random_bytes(60, 1'b0);
    settle();
    set_line_limit(6'd3);
    send_messages(20);
    settle();
    set_line_limit(6'd19);
    send_messages(20);
    settle();

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/b64lw_pkg.sv
rtl/b64lw_front.sv
rtl/b64lw_fifo.sv
rtl/b64lw_back.sv
rtl/base64_encoder_line_wrap.sv
tb/sv/base64_char_checker.sv
tb/sv/tb_base64_encoder_line_wrap.sv
